>>> hw/rtl/sbr_pkg.sv
// sbr_pkg: shared constants, beat types and state codes for the softmax backward row block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sbr_pkg;

    localparam int MAX_COLS   = 64;
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 12;

    localparam int ADDR_W  = $clog2(MAX_COLS);
    localparam int COUNT_W = $clog2(MAX_COLS + 1);
    localparam int MUL_W   = 2 * DATA_WIDTH;
    localparam int ACC_W   = MUL_W + ADDR_W + 2;
    localparam int DIFF_W  = ACC_W + 1;
    localparam int PROD_W  = DIFF_W + DATA_WIDTH;
    localparam int RND_W   = PROD_W - 2 * FRAC_BITS;
    localparam int PAIR_W  = 2 * DATA_WIDTH;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] y_value;
        logic signed [DATA_WIDTH-1:0] dy_value;
        logic                         row_end;
    } in_beat_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] dx_value;
        logic                         last_of_row;
        logic                         row_overflow;
    } out_beat_t;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } sbr_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/sbr_ram.sv
// sbr_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module sbr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/softmax_backward_row.sv
// softmax_backward_row: row-streamed softmax gradient dx = (dy - sum(y*dy)) * y
// depends on sbr_pkg and sbr_ram
// load: one beat per cycle; first MAX_COLS pairs go to the pair ram, products accumulated
// emit: results follow the row-end beat, one result per cycle while out_stall is low, through
// ram read, difference, multiply and round/saturate stages; the next row is accepted
// after the last result beat leaves
// reset clears row count, accumulator, overflow flag and all valid bits; ram is not cleared
`timescale 1ns / 1ps
`default_nettype none

module softmax_backward_row (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire sbr_pkg::in_beat_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output sbr_pkg::out_beat_t      out_data
);

    import sbr_pkg::*;

    sbr_state_t                 state_reg, state_next;
    logic [COUNT_W-1:0]         count_reg, count_next;
    logic [COUNT_W-1:0]         issue_reg, issue_next;
    logic signed [ACC_W-1:0]    sum_reg, sum_next;
    logic                       flag_reg, flag_next;
    logic                       pv_reg, pv_next;
    logic signed [MUL_W-1:0]    prod_reg;

    logic                       s1_valid_reg, s1_valid_next;
    logic                       s1_last_reg;
    logic                       s2_valid_reg, s2_valid_next;
    logic                       s2_last_reg;
    logic signed [DIFF_W-1:0]   s2_diff_reg;
    logic signed [DATA_WIDTH-1:0] s2_y_reg;
    logic                       s3_valid_reg, s3_valid_next;
    logic                       s3_last_reg;
    logic signed [PROD_W-1:0]   s3_prod_reg;
    logic                       out_valid_reg, out_valid_next;
    out_beat_t                  out_reg;

    logic                       accept;
    logic                       store;
    logic                       adv;
    logic                       issue;
    logic                       issue_last;
    logic                       row_done;
    logic [PAIR_W-1:0]          rd_pair;
    logic signed [DATA_WIDTH-1:0] rd_y;
    logic signed [DATA_WIDTH-1:0] rd_dy;
    logic signed [DIFF_W-1:0]   diff;
    logic                       neg;
    logic [PROD_W-1:0]          mag;
    logic [PROD_W-1:0]          mag_rnd;
    logic [RND_W-1:0]           rnd;
    logic [RND_W-1:0]           lim;
    logic [RND_W-1:0]           sat;
    logic [DATA_WIDTH-1:0]      dx;

    assign in_stall  = (state_reg != ST_LOAD);
    assign accept    = in_valid && !in_stall;
    assign store     = accept && (count_reg < COUNT_W'(MAX_COLS));
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign adv       = !out_valid_reg || !out_stall;
    assign row_done  = out_valid_reg && !out_stall && out_reg.last_of_row;
    assign issue     = (state_reg == ST_EMIT) && (issue_reg < count_reg) && adv;
    assign issue_last = (issue_reg == count_reg - COUNT_W'(1));

    sbr_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (MAX_COLS)
    ) u_pair_ram (
        .clk   (clk),
        .we    (store),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata ({in_data.y_value, in_data.dy_value}),
        .re    (adv),
        .raddr (issue_reg[ADDR_W-1:0]),
        .rdata (rd_pair)
    );

    assign rd_y  = rd_pair[PAIR_W-1:DATA_WIDTH];
    assign rd_dy = rd_pair[DATA_WIDTH-1:0];
    assign diff  = (DIFF_W'(rd_dy) <<< FRAC_BITS) - DIFF_W'(sum_reg);

    // round half away from zero on the magnitude, then saturate
    always_comb
    begin
        neg     = s3_prod_reg[PROD_W-1];
        mag     = neg ? PROD_W'(-s3_prod_reg) : PROD_W'(s3_prod_reg);
        mag_rnd = mag + (PROD_W'(1) << (2 * FRAC_BITS - 1));
        rnd     = mag_rnd[PROD_W-1:2*FRAC_BITS];
        lim     = neg ? (RND_W'(1) << (DATA_WIDTH - 1))
                      : ((RND_W'(1) << (DATA_WIDTH - 1)) - RND_W'(1));
        sat     = (rnd > lim) ? lim : rnd;
        dx      = neg ? DATA_WIDTH'(-sat) : sat[DATA_WIDTH-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        sum_next       = sum_reg;
        flag_next      = flag_reg;
        pv_next        = store;
        s1_valid_next  = s1_valid_reg;
        s2_valid_next  = s2_valid_reg;
        s3_valid_next  = s3_valid_reg;
        out_valid_next = out_valid_reg;

        if (pv_reg)
        begin
            sum_next = sum_reg + ACC_W'(prod_reg);
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (store)
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                    else
                    begin
                        flag_next = 1'b1;
                    end
                    if (in_data.row_end)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (issue)
                begin
                    issue_next = issue_reg + COUNT_W'(1);
                end
                if (row_done)
                begin
                    state_next = ST_LOAD;
                    count_next = '0;
                    issue_next = '0;
                    sum_next   = '0;
                    flag_next  = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        if (adv)
        begin
            s1_valid_next  = issue;
            s2_valid_next  = s1_valid_reg;
            s3_valid_next  = s2_valid_reg;
            out_valid_next = s3_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            issue_reg     <= '0;
            sum_reg       <= '0;
            flag_reg      <= 1'b0;
            pv_reg        <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            sum_reg       <= sum_next;
            flag_reg      <= flag_next;
            pv_reg        <= pv_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        prod_reg <= in_data.y_value * in_data.dy_value;
        if (adv)
        begin
            s1_last_reg          <= issue_last;
            s2_last_reg          <= s1_last_reg;
            s2_diff_reg          <= diff;
            s2_y_reg             <= rd_y;
            s3_last_reg          <= s2_last_reg;
            s3_prod_reg          <= s2_diff_reg * PROD_W'(s2_y_reg);
            out_reg.dx_value     <= dx;
            out_reg.last_of_row  <= s3_last_reg;
            out_reg.row_overflow <= flag_reg;
        end
    end

endmodule

`default_nettype wire
